>>> rtl/lpg_pkg.sv
package lpg_pkg;

    // Default coordinate width (bits of one signed pixel coordinate).
    localparam int LPG_COORD_BITS = 12;

    // Frame size registers are fixed at twelve bits.
    localparam int LPG_DIM_BITS = 12;
    localparam logic [LPG_DIM_BITS-1:0] LPG_FRAME_WIDTH_RST  = 12'd640;
    localparam logic [LPG_DIM_BITS-1:0] LPG_FRAME_HEIGHT_RST = 12'd480;

    // Configuration port geometry.
    localparam int LPG_APB_AW = 3;
    localparam int LPG_APB_DW = 32;
    localparam int LPG_COLOR_BITS = 32;

    // Register index, taken from paddr bit 2.
    typedef enum logic [0:0] {
        LPG_REG_FRAME_WIDTH  = 1'b0,
        LPG_REG_FRAME_HEIGHT = 1'b1
    } t_lpg_reg;

    // Input beat kind, carried on tuser.
    typedef enum logic [0:0] {
        LPG_KIND_START = 1'b0,
        LPG_KIND_STEP  = 1'b1
    } t_lpg_kind;

endpackage

>>> rtl/lpg_cfg.sv
module lpg_cfg
    import lpg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [LPG_APB_AW-1:0]     paddr,
    input  logic [LPG_APB_DW-1:0]     pwdata,
    output logic [LPG_APB_DW-1:0]     prdata,
    output logic                      pready,
    output logic [LPG_DIM_BITS-1:0]   o_frame_width,
    output logic [LPG_DIM_BITS-1:0]   o_frame_height
);

    logic [LPG_DIM_BITS-1:0] r_frame_width;
    logic [LPG_DIM_BITS-1:0] r_frame_height;
    t_lpg_reg                reg_sel;
    logic                    wr_en;

    assign reg_sel = t_lpg_reg'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= LPG_FRAME_WIDTH_RST;
            r_frame_height <= LPG_FRAME_HEIGHT_RST;
        end else if (wr_en) begin
            case (reg_sel)
                LPG_REG_FRAME_WIDTH:  r_frame_width  <= pwdata[LPG_DIM_BITS-1:0];
                LPG_REG_FRAME_HEIGHT: r_frame_height <= pwdata[LPG_DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            LPG_REG_FRAME_WIDTH:  prdata = LPG_APB_DW'(r_frame_width);
            LPG_REG_FRAME_HEIGHT: prdata = LPG_APB_DW'(r_frame_height);
            default:              prdata = '0;
        endcase
    end

    assign o_frame_width  = r_frame_width;
    assign o_frame_height = r_frame_height;

endmodule

>>> rtl/lpg_core.sv
module lpg_core
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = LPG_COORD_BITS
)
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Item from the input register.
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  t_lpg_kind                   i_kind,
    input  logic [COORD_BITS-1:0]       i_start_x,
    input  logic [COORD_BITS-1:0]       i_start_y,
    input  logic [COORD_BITS-1:0]       i_end_x,
    input  logic [COORD_BITS-1:0]       i_end_y,
    input  logic [LPG_COLOR_BITS-1:0]   i_color,
    // Clip window.
    input  logic [LPG_DIM_BITS-1:0]     i_frame_width,
    input  logic [LPG_DIM_BITS-1:0]     i_frame_height,
    // Result register.
    output logic                        o_out_vld,
    input  logic                        i_out_rdy,
    output logic [COORD_BITS-1:0]       o_pixel_x,
    output logic [COORD_BITS-1:0]       o_pixel_y,
    output logic [LPG_COLOR_BITS-1:0]   o_pixel_color,
    output logic                        o_in_frame,
    output logic                        o_last
);

    localparam int EW = COORD_BITS + 2;   // error term width, signed
    localparam int CW = (COORD_BITS > LPG_DIM_BITS) ? COORD_BITS : LPG_DIM_BITS;

    // Line state.
    logic signed [COORD_BITS-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic        [COORD_BITS-1:0] r_dx, r_dy;
    logic                         r_x_neg, r_y_neg;
    logic signed [EW-1:0]         r_err;
    logic [LPG_COLOR_BITS-1:0]    r_color;
    logic                         r_busy;

    logic signed [COORD_BITS-1:0] n_cur_x, n_cur_y;
    logic        [COORD_BITS-1:0] n_dx, n_dy;
    logic signed [EW-1:0]         n_err;

    // Result register.
    logic                         r_out_vld;
    logic [COORD_BITS-1:0]        r_pix_x, r_pix_y;
    logic [LPG_COLOR_BITS-1:0]    r_pix_color;
    logic                         r_in_frame, r_last;

    logic                         fire, is_start, emit, fin, in_win;
    logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
    logic                         x_lt, y_lt;
    logic signed [EW:0]           e2;
    logic signed [EW:0]           dx_ext, dy_ext;
    logic                         step_x, step_y;

    assign o_rdy    = !r_out_vld || i_out_rdy;
    assign fire     = i_vld && o_rdy;
    assign is_start = (i_kind == LPG_KIND_START);
    assign emit     = fire && !is_start && r_busy;

    assign sx = $signed(i_start_x);
    assign sy = $signed(i_start_y);
    assign ex = $signed(i_end_x);
    assign ey = $signed(i_end_y);
    assign x_lt = sx < ex;
    assign y_lt = sy < ey;

    // Start: absolute deltas; the difference always fits COORD_BITS unsigned.
    assign n_dx = x_lt ? COORD_BITS'(ex - sx) : COORD_BITS'(sx - ex);
    assign n_dy = y_lt ? COORD_BITS'(ey - sy) : COORD_BITS'(sy - ey);

    // Step: the usual error rule on the doubled error term.
    assign fin    = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
    assign e2     = {r_err, 1'b0};
    assign dx_ext = $signed({{(EW + 1 - COORD_BITS){1'b0}}, r_dx});
    assign dy_ext = $signed({{(EW + 1 - COORD_BITS){1'b0}}, r_dy});
    assign step_x = e2 > -dy_ext;
    assign step_y = e2 < dx_ext;

    always_comb begin
        n_err   = r_err;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (step_x) begin
            n_err   = n_err - EW'(dy_ext);
            n_cur_x = r_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        end
        if (step_y) begin
            n_err   = n_err + EW'(dx_ext);
            n_cur_y = r_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
    end

    // Clip test: a non-negative coordinate compared unsigned against the frame.
    assign in_win = !r_cur_x[COORD_BITS-1] && !r_cur_y[COORD_BITS-1] &&
                    (CW'(r_cur_x) < CW'(i_frame_width)) &&
                    (CW'(r_cur_y) < CW'(i_frame_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_tgt_x <= '0;
            r_tgt_y <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_x_neg <= 1'b0;
            r_y_neg <= 1'b0;
            r_err   <= '0;
            r_color <= '0;
            r_busy  <= 1'b0;
        end else if (fire && is_start) begin
            r_cur_x <= sx;
            r_cur_y <= sy;
            r_tgt_x <= ex;
            r_tgt_y <= ey;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_x_neg <= !x_lt;
            r_y_neg <= !y_lt;
            r_err   <= EW'(n_dx) - EW'(n_dy);
            r_color <= i_color;
            r_busy  <= 1'b1;
        end else if (emit) begin
            if (fin) begin
                r_busy <= 1'b0;
            end else begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_rdy) begin
            r_out_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pix_x     <= r_cur_x;
            r_pix_y     <= r_cur_y;
            r_pix_color <= r_color;
            r_in_frame  <= in_win;
            r_last      <= fin;
        end
    end

    assign o_out_vld     = r_out_vld;
    assign o_pixel_x     = r_pix_x;
    assign o_pixel_y     = r_pix_y;
    assign o_pixel_color = r_pix_color;
    assign o_in_frame    = r_in_frame;
    assign o_last        = r_last;

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_start) |=> r_busy)
        else $error("start beat did not arm the line");

    a_end_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && fin) |=> (!r_busy && r_out_vld && r_last))
        else $error("end point did not close the line");

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !is_start && !r_busy) |=> (!r_busy && !r_out_vld))
        else $error("step beat while idle produced a pixel");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_out_vld && (r_pix_color == $past(r_color))))
        else $error("emitted pixel missing from result register");

endmodule

>>> rtl/line_pixel_generator.sv
// Path: a step beat taken on the slave side passes through the input register and the
// result register before it is offered on the master side.
// Throughput: one beat per cycle, start or step, unless the master side stalls; each step beat while a line
// runs produces one pixel beat, set by the single error-update pass between the input and result registers.
// Reset (i_rst_n, synchronous, active low): no line running, both pipeline registers empty,
// frame size 640 by 480.
module line_pixel_generator
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = LPG_COORD_BITS
)
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [LPG_APB_AW-1:0]           paddr,
    input  logic [LPG_APB_DW-1:0]           pwdata,
    output logic [LPG_APB_DW-1:0]           prdata,
    output logic                            pready,

    // Slave side: command beats.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata, lowest bit up: start_x, start_y, end_x, end_y, color, zero padding
    input  logic [((4*COORD_BITS+LPG_COLOR_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: kind (0 start a line, 1 step one pixel)
    input  logic                            s_tuser,

    // Master side: pixel beats.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata, lowest bit up: pixel_x, pixel_y, pixel_color, zero padding
    output logic [((2*COORD_BITS+LPG_COLOR_BITS+7)/8)*8-1:0] m_tdata,
    // tuser: in_frame
    output logic                            m_tuser,
    // tlast: the pixel is the end point of its line
    output logic                            m_tlast
);

    localparam int IN_DW  = ((4*COORD_BITS + LPG_COLOR_BITS + 7) / 8) * 8;
    localparam int OUT_DW = ((2*COORD_BITS + LPG_COLOR_BITS + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_DW - (2*COORD_BITS + LPG_COLOR_BITS);

    logic [LPG_DIM_BITS-1:0] frame_width;
    logic [LPG_DIM_BITS-1:0] frame_height;

    // Input register. It loads whenever it is empty or the core takes its
    // contents, so a new beat can enter every cycle while the core keeps taking them.
    logic                       r_in_vld;
    t_lpg_kind                  r_in_kind;
    logic [IN_DW-1:0]           r_in_data;
    logic                       core_rdy;

    logic [COORD_BITS-1:0]      pix_x, pix_y;
    logic [LPG_COLOR_BITS-1:0]  pix_color;

    assign s_tready = !r_in_vld || core_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_tready) begin
            r_in_vld <= s_tvalid;
        end
    end

    // Payload needs no reset; it only loads on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_kind <= t_lpg_kind'(s_tuser);
            r_in_data <= s_tdata;
        end
    end

    lpg_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_frame_width  (frame_width),
        .o_frame_height (frame_height)
    );

    // The core holds the line state, steps it once per step beat, and keeps
    // the result register that feeds the master side.
    lpg_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (r_in_vld),
        .o_rdy          (core_rdy),
        .i_kind         (r_in_kind),
        .i_start_x      (r_in_data[0*COORD_BITS +: COORD_BITS]),
        .i_start_y      (r_in_data[1*COORD_BITS +: COORD_BITS]),
        .i_end_x        (r_in_data[2*COORD_BITS +: COORD_BITS]),
        .i_end_y        (r_in_data[3*COORD_BITS +: COORD_BITS]),
        .i_color        (r_in_data[4*COORD_BITS +: LPG_COLOR_BITS]),
        .i_frame_width  (frame_width),
        .i_frame_height (frame_height),
        .o_out_vld      (m_tvalid),
        .i_out_rdy      (m_tready),
        .o_pixel_x      (pix_x),
        .o_pixel_y      (pix_y),
        .o_pixel_color  (pix_color),
        .o_in_frame     (m_tuser),
        .o_last         (m_tlast)
    );

    // Pack the pixel beat; the top bits are zero padding to a byte boundary.
    generate
        if (OUT_PAD > 0) begin : g_pad
            assign m_tdata = {{OUT_PAD{1'b0}}, pix_color, pix_y, pix_x};
        end else begin : g_nopad
            assign m_tdata = {pix_color, pix_y, pix_x};
        end
    endgenerate

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lpg_pkg::*;

    // Field geometry of the two streams, taken from the package so the
    // testbench follows the block's default coordinate width.
    localparam int CB    = LPG_COORD_BITS;
    localparam int CLR_W = LPG_COLOR_BITS;
    localparam int SD_W  = ((4*CB+CLR_W+7)/8)*8;
    localparam int MD_W  = ((2*CB+CLR_W+7)/8)*8;
    localparam int COORD_MIN = -(1 << (CB-1));
    localparam int COORD_MAX = (1 << (CB-1)) - 1;

    // One emitted pixel as it appears on the master side.
    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic [CLR_W-1:0]     color;
        logic                 in_frame;
        logic                 last;
    } t_pixel;

    // Line tracker: mirrors the Bresenham walk of the block and holds the
    // pixels that are still owed on the master side, oldest first.
    class pixel_scoreboard;
        t_pixel               owed_pixels[$];
        logic signed [CB-1:0] pos_x, pos_y, goal_x, goal_y;
        logic [CB-1:0]        span_x, span_y;
        bit                   dir_x_neg, dir_y_neg;
        logic signed [CB+1:0] err;
        logic [CLR_W-1:0]     stroke_color;
        bit                   drawing;
        logic [LPG_DIM_BITS-1:0] frame_w, frame_h;
        int errors, starts_seen, pixels_checked, in_frame_seen, ends_seen;

        function new();
            frame_w = LPG_FRAME_WIDTH_RST;
            frame_h = LPG_FRAME_HEIGHT_RST;
            pos_x = '0; pos_y = '0; goal_x = '0; goal_y = '0;
            span_x = '0; span_y = '0; err = '0; stroke_color = '0;
            dir_x_neg = 0; dir_y_neg = 0; drawing = 0;
            errors = 0; starts_seen = 0; pixels_checked = 0;
            in_frame_seen = 0; ends_seen = 0;
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        function void set_frame(t_lpg_reg idx, logic [LPG_DIM_BITS-1:0] val);
            if (idx == LPG_REG_FRAME_WIDTH) frame_w = val;
            else frame_h = val;
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        // Called for every accepted slave-side beat.
        function void note_beat(t_lpg_kind kind, logic [SD_W-1:0] data);
            int     x0, y0, x1, y1, e2;
            t_pixel px;
            if (kind == LPG_KIND_START) begin
                x0 = int'($signed(data[0*CB +: CB]));
                y0 = int'($signed(data[1*CB +: CB]));
                x1 = int'($signed(data[2*CB +: CB]));
                y1 = int'($signed(data[3*CB +: CB]));
                pos_x = CB'(x0); pos_y = CB'(y0); goal_x = CB'(x1); goal_y = CB'(y1);
                span_x = CB'((x0 > x1) ? x0 - x1 : x1 - x0);
                span_y = CB'((y0 > y1) ? y0 - y1 : y1 - y0);
                dir_x_neg = !(x0 < x1);
                dir_y_neg = !(y0 < y1);
                err = (CB+2)'(int'(span_x) - int'(span_y));
                stroke_color = data[4*CB +: CLR_W];
                drawing = 1;
                starts_seen++;
            end else if (drawing) begin
                px.x = pos_x;
                px.y = pos_y;
                px.color = stroke_color;
                px.in_frame = (int'(pos_x) >= 0) && (int'(pos_x) < int'(frame_w)) &&
                              (int'(pos_y) >= 0) && (int'(pos_y) < int'(frame_h));
                px.last = (pos_x == goal_x) && (pos_y == goal_y);
                owed_pixels.push_back(px);
                if (px.last) begin
                    drawing = 0;
                end else begin
                    e2 = 2 * int'(err);
                    if (e2 > -int'(span_y)) begin
                        err = (CB+2)'(int'(err) - int'(span_y));
                        pos_x = CB'(int'(pos_x) + (dir_x_neg ? -1 : 1));
                    end
                    if (e2 < int'(span_x)) begin
                        err = (CB+2)'(int'(err) + int'(span_x));
                        pos_y = CB'(int'(pos_y) + (dir_y_neg ? -1 : 1));
                    end
                end
            end
        endfunction

        // Called for every accepted master-side beat.
        task check_pixel(t_pixel got);
            t_pixel want;
            if (owed_pixels.size() == 0) begin
                report($sformatf("pixel (%0d,%0d) arrived with none outstanding",
                                 got.x, got.y));
            end else begin
                want = owed_pixels.pop_front();
                pixels_checked++;
                if (want.in_frame) in_frame_seen++;
                if (want.last) ends_seen++;
                if (got.x !== want.x)
                    report($sformatf("pixel_x %0d, wanted %0d", got.x, want.x));
                if (got.y !== want.y)
                    report($sformatf("pixel_y %0d, wanted %0d", got.y, want.y));
                if (got.color !== want.color)
                    report($sformatf("color %h, wanted %h", got.color, want.color));
                if (got.in_frame !== want.in_frame)
                    report($sformatf("in_frame %b, wanted %b at (%0d,%0d)",
                                     got.in_frame, want.in_frame, want.x, want.y));
                if (got.last !== want.last)
                    report($sformatf("last %b, wanted %b at (%0d,%0d)",
                                     got.last, want.last, want.x, want.y));
            end
        endtask
    endclass

    // Every input of the block starts at a known value.
    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [LPG_APB_AW-1:0]  paddr   = '0;
    logic [LPG_APB_DW-1:0]  pwdata  = '0;
    logic [LPG_APB_DW-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SD_W-1:0]        s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [MD_W-1:0]        m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // Idle and stall rates in percent, changed from phase to phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Frame size currently programmed, used to aim lines at the frame edges.
    int cfg_w = LPG_FRAME_WIDTH_RST;
    int cfg_h = LPG_FRAME_HEIGHT_RST;
    int settings_used = 1;

    pixel_scoreboard sb;

    line_pixel_generator i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver drops tready at the rate of the current phase.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Both streams are sampled at the edge where the handshake completes.
    // Every block output and every testbench drive changes only through
    // nonblocking updates, so the values seen here are the pre-edge ones.
    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.x        = m_tdata[0*CB +: CB];
                got.y        = m_tdata[1*CB +: CB];
                got.color    = m_tdata[2*CB +: CLR_W];
                got.in_frame = m_tuser;
                got.last     = m_tlast;
                sb.check_pixel(got);
            end
            if (s_tvalid && s_tready) begin
                sb.note_beat(t_lpg_kind'(s_tuser), s_tdata);
            end
        end
    end

    // Present one slave-side beat, after an optional run of idle cycles,
    // and return at the edge where it is accepted.
    task automatic send_beat(t_lpg_kind kind, logic [SD_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic start_line(int sx, int sy, int ex, int ey, logic [CLR_W-1:0] color);
        logic [CB-1:0] fx0, fy0, fx1, fy1;
        fx0 = CB'(sx); fy0 = CB'(sy); fx1 = CB'(ex); fy1 = CB'(ey);
        send_beat(LPG_KIND_START, {color, fy1, fx1, fy0, fx0});
    endtask

    // Step beats carry random payload, which the block must ignore.
    task automatic step_beats(int count);
        repeat (count) send_beat(LPG_KIND_STEP, SD_W'({$urandom, $urandom, $urandom}));
    endtask

    function automatic int clamp_coord(int v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // Number of pixels a Bresenham walk visits between two points.
    function automatic int line_length(int sx, int sy, int ex, int ey);
        int dx, dy;
        dx = (sx > ex) ? sx - ex : ex - sx;
        dy = (sy > ey) ? sy - ey : ey - sy;
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    // Pick endpoints: mostly short lines, half of them around the frame
    // so the clip test flips, a few medium ones and rarely a full-range one.
    task automatic pick_line(output int sx, output int sy, output int ex, output int ey);
        int size_pick, reach, cx, cy;
        size_pick = $urandom_range(99);
        if (size_pick == 99) begin
            sx = int'($signed(CB'($urandom)));
            sy = int'($signed(CB'($urandom)));
            ex = int'($signed(CB'($urandom)));
            ey = int'($signed(CB'($urandom)));
        end else begin
            reach = (size_pick < 94) ? 6 : 64;
            if ($urandom_range(1)) begin
                cx = int'($urandom_range(cfg_w + 1)) - 1;
                cy = int'($urandom_range(cfg_h + 1)) - 1;
            end else begin
                cx = int'($signed(CB'($urandom)));
                cy = int'($signed(CB'($urandom)));
            end
            sx = clamp_coord(cx + int'($urandom_range(2*reach)) - reach);
            sy = clamp_coord(cy + int'($urandom_range(2*reach)) - reach);
            ex = clamp_coord(cx + int'($urandom_range(2*reach)) - reach);
            ey = clamp_coord(cy + int'($urandom_range(2*reach)) - reach);
        end
    endtask

    // Random traffic: mostly complete lines, some cut short by a new start,
    // and some raw beats of either kind with random payload.
    task automatic run_random(int budget);
        int sent, pick, sx, sy, ex, ey, len, cut, burst;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            pick_line(sx, sy, ex, ey);
            len = line_length(sx, sy, ex, ey);
            if (len > 129) begin
                // A full-range line is walked only part of the way so the
                // run keeps close to its beat budget.
                cut = $urandom_range(64);
                start_line(sx, sy, ex, ey, $urandom);
                step_beats(cut);
                sent += 1 + cut;
            end else if (pick < 85) begin
                start_line(sx, sy, ex, ey, $urandom);
                step_beats(len);
                sent += 1 + len;
                // A few steps past the end point must produce nothing.
                if ($urandom_range(9) == 0) step_beats($urandom_range(1, 2));
            end else if (pick < 93) begin
                cut = $urandom_range(len - 1);
                start_line(sx, sy, ex, ey, $urandom);
                step_beats(cut);
                sent += 1 + cut;
            end else begin
                burst = $urandom_range(1, 4);
                repeat (burst) begin
                    send_beat(t_lpg_kind'($urandom_range(1)),
                              SD_W'({$urandom, $urandom, $urandom}));
                end
                sent += burst;
            end
        end
    endtask

    // Stop sending and wait for every owed pixel, then let the pipeline
    // empty of steps that produce nothing before anything else happens.
    task automatic drain_lines();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_frame(t_lpg_reg idx, logic [LPG_DIM_BITS-1:0] val);
        logic [LPG_APB_DW-1:0] word;
        word = $urandom;
        word[LPG_DIM_BITS-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_frame(idx, val);
        if (idx == LPG_REG_FRAME_WIDTH) cfg_w = val;
        else cfg_h = val;
        @(posedge i_clk);
    endtask

    task automatic read_frame(t_lpg_reg idx);
        logic [LPG_DIM_BITS-1:0] want;
        want = (idx == LPG_REG_FRAME_WIDTH) ? sb.frame_w : sb.frame_h;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[LPG_DIM_BITS-1:0] !== want)
            sb.report($sformatf("register %s reads %0d, wanted %0d",
                                idx.name(), prdata[LPG_DIM_BITS-1:0], want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_frame(int w, int h);
        write_frame(LPG_REG_FRAME_WIDTH, LPG_DIM_BITS'(w));
        write_frame(LPG_REG_FRAME_HEIGHT, LPG_DIM_BITS'(h));
        read_frame(LPG_REG_FRAME_WIDTH);
        read_frame(LPG_REG_FRAME_HEIGHT);
        settings_used++;
    endtask

    // Hand-picked beats: coordinate and color extremes, the frame edges,
    // a one-pixel line, steps with no line running, and a line that is
    // abandoned by a new start.
    task automatic run_directed();
        step_beats(1);
        start_line(0, 0, 0, 0, 32'hFFFF_FFFF);
        step_beats(2);
        start_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'h0000_0000);
        step_beats(2);
        start_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 32'hAAAA_AAAA);
        step_beats(2);
        start_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32'h5555_5555);
        step_beats(1);
        start_line(638, 478, 641, 481, 32'h1234_5678);
        step_beats(4);
        start_line(-1, -2, 1, 0, 32'h8000_0001);
        step_beats(3);
        start_line(5, 10, 5, 7, 32'h7FFF_FFFE);
        step_beats(5);
    endtask

    // Hard ceiling on the run; the slowest legal run is far shorter.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase 0: reset frame size, no idling at all.
        read_frame(LPG_REG_FRAME_WIDTH);
        read_frame(LPG_REG_FRAME_HEIGHT);
        run_directed();
        run_random(240);
        drain_lines();

        // Phase 1: sender idles often; a one-pixel frame.
        send_idle_pct = 68; recv_stall_pct = 0;
        program_frame(1, 1);
        run_random(240);
        drain_lines();

        // Phase 2: receiver stalls often; a 2048 by 2047 frame.
        send_idle_pct = 0; recv_stall_pct = 68;
        program_frame(2048, 2047);
        run_random(240);
        drain_lines();

        // Phase 3: light idling on both sides; random frame size.
        send_idle_pct = 11; recv_stall_pct = 11;
        program_frame($urandom_range(1, 2048), $urandom_range(1, 2048));
        run_random(240);
        drain_lines();

        // Phase 4: no idling; widest register value against a one-row frame.
        send_idle_pct = 0; recv_stall_pct = 0;
        program_frame(4095, 1);
        run_random(240);
        drain_lines();

        // Give the block time to emit anything unexpected before judging.
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d pixels never arrived", sb.pending()));

        $display("Checked %0d pixels from %0d line starts: %0d inside the frame, %0d end points.",
                 sb.pixels_checked, sb.starts_seen, sb.in_frame_seen, sb.ends_seen);
        $display("Traffic ran over 5 idle and stall mixes and %0d frame size settings.",
                 settings_used);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> line_pixel_generator.f
rtl/lpg_pkg.sv
rtl/lpg_cfg.sv
rtl/lpg_core.sv
rtl/line_pixel_generator.sv
tb/tb_top.sv
